### hw/rtl/erw_pkg.sv
// erw_pkg: widths, limits and register indexes of the ECG rhythm alarm window.
// No dependencies; every other file of the block imports it.
package erw_pkg;

  // Ring store depth and derived widths
  localparam int DEPTH    = 128;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Field widths
  localparam int RR_W     = 16;
  localparam int Q_W      = 10;
  localparam int RATE_W   = 12;
  localparam int TOTAL_W  = 32;
  localparam int BPM_W    = 9;

  // Rate and alarm arithmetic
  localparam int RR_VALID_MAX    = 3000;
  localparam int MIN_BEATS       = 5;
  localparam int RATE_NUM_TENTHS = 600000;
  localparam int RATE_NUM_BPM    = 60000;
  localparam int RATE_MAX        = (1 << RATE_W) - 1;

  // The scan stops once the sum reaches a 16-bit window, so one more RR fits
  localparam int ACC_W    = $clog2((1 << RR_W) + RR_VALID_MAX);
  localparam int QACC_W   = $clog2(DEPTH * ((1 << Q_W) - 1) + 1);
  localparam int NUM_W    = $clog2(DEPTH * RATE_NUM_TENTHS + 1);
  localparam int DIV_W    = (NUM_W > ACC_W + RATE_W) ? NUM_W : ACC_W + RATE_W;
  localparam int BS_W     = CNT_W + $clog2(RATE_NUM_BPM + 1);
  localparam int CMP_W    = (BS_W > ACC_W + BPM_W) ? BS_W : ACC_W + BPM_W;
  localparam int GATE_W   = (QACC_W > Q_W + CNT_W) ? QACC_W : Q_W + CNT_W;
  localparam int BIT_W    = $clog2(RATE_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ASY_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QGATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRADY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TACHY     = 3'd4;

  // Register reset values
  localparam logic [RR_W-1:0]  ASY_LIMIT_RST = 16'd4000;
  localparam logic [RR_W-1:0]  WINDOW_RST    = 16'd30000;
  localparam logic [Q_W-1:0]   QGATE_RST     = 10'd500;
  localparam logic [BPM_W-1:0] BRADY_RST     = 9'd40;
  localparam logic [BPM_W-1:0] TACHY_RST     = 9'd150;

endpackage

### hw/rtl/erw_beat_if.sv
// erw_beat_if: valid/ready channel carrying one heartbeat record per beat.
// Depends on erw_pkg.
interface erw_beat_if;
  import erw_pkg::*;

  logic            valid;
  logic            ready;
  logic            beat_present;
  logic [RR_W-1:0] rr_ms;
  logic [Q_W-1:0]  quality;

  modport source (output valid, beat_present, rr_ms, quality, input ready);
  modport sink   (input valid, beat_present, rr_ms, quality, output ready);
endinterface

### hw/rtl/erw_alarm_if.sv
// erw_alarm_if: valid/ready channel carrying one alarm result per beat.
// Depends on erw_pkg.
interface erw_alarm_if;
  import erw_pkg::*;

  logic               valid;
  logic               ready;
  logic               asystole;
  logic               bradycardia;
  logic               tachycardia;
  logic [RATE_W-1:0]  window_rate;
  logic [TOTAL_W-1:0] asystole_total;

  modport source (output valid, asystole, bradycardia, tachycardia, window_rate,
                  asystole_total, input ready);
  modport sink   (input valid, asystole, bradycardia, tachycardia, window_rate,
                  asystole_total, output ready);
endinterface

### hw/rtl/erw_div.sv
// erw_div: restoring divider giving a saturated RATE_W-bit quotient,
// one quotient bit per cycle. Depends on erw_pkg.
module erw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [erw_pkg::NUM_W-1:0] num,
  input  logic [erw_pkg::ACC_W-1:0] den,
  output logic                      done,
  output logic [erw_pkg::RATE_W-1:0] quot
);
  import erw_pkg::*;

  logic             busy;
  logic [BIT_W-1:0] bitn;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [DIV_W-1:0] den_top;
  logic [DIV_W-1:0] num_ext;

  assign den_top = DIV_W'(den) << RATE_W;
  assign num_ext = DIV_W'(num);

  // Saturate up front, else shift-subtract from the top quotient bit down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        rem <= num_ext;
        dsh <= den_top >> 1;
        bitn <= BIT_W'(RATE_W - 1);
        if (num_ext >= den_top) begin
          quot <= RATE_W'(RATE_MAX);
          done <= 1'b1;
        end else begin
          quot <= '0;
          busy <= 1'b1;
          done <= 1'b0;
        end
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quot[bitn] <= 1'b1;
        end
        dsh <= dsh >> 1;
        if (bitn == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitn <= bitn - 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule

### hw/rtl/ecg_rhythm_alarm_window.sv
// ecg_rhythm_alarm_window: per-beat asystole, bradycardia and tachycardia alarm
// over an RR averaging window kept in a ring memory. Uses erw_pkg, erw_beat_if,
// erw_alarm_if and erw_div.
//
//   channel  dir  handshake     payload
//   beat     in   valid/ready   beat_present, rr_ms, quality
//   alarm    out  valid/ready   asystole, bradycardia, tachycardia, window_rate,
//                               asystole_total
//   cfg      in   cfg_we only   cfg_index, cfg_data
//
// A beat without a window update (no beat, asystole, RR out of range) goes from
// acceptance through the emit state into the output register. A stored beat walks
// the ring memory from the oldest entry at one entry per cycle; if the window is
// covered by MIN_BEATS beats or more, multiply, compare and the divider follow.
// One beat is in work at a time; the next is taken once its result sits in the
// output register. Reset is synchronous; the ring memory is not cleared, as only
// written entries are ever scanned. A stalled output holds the block.
module ecg_rhythm_alarm_window (
  input  logic                           clk,
  input  logic                           rst,
  erw_beat_if.sink                       beat,
  erw_alarm_if.source                    alarm,
  input  logic                           cfg_we,
  input  logic [erw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MUL, S_CMP, S_DIV, S_EMIT
  } state_t;

  // Configuration registers
  logic [RR_W-1:0]  asy_limit;
  logic [RR_W-1:0]  window;
  logic [Q_W-1:0]   qgate;
  logic [BPM_W-1:0] brady;
  logic [BPM_W-1:0] tachy;

  // Ring memory
  logic [RR_W-1:0] rr_mem [DEPTH];
  logic [Q_W-1:0]  q_mem  [DEPTH];
  logic [RR_W-1:0] rr_q;
  logic [Q_W-1:0]  q_q;
  logic            wr_en;
  logic            rd_en;

  // Control state
  state_t             state;
  logic [PTR_W-1:0]   wp;
  logic [CNT_W-1:0]   fill;
  logic [TOTAL_W-1:0] asy_count;
  logic [PTR_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   iss;
  logic               pend;

  // Window accumulation
  logic [ACC_W-1:0]  acc;
  logic [QACC_W-1:0] qacc;
  logic [CNT_W-1:0]  n;
  logic [ACC_W-1:0]  acc_sum;

  // Products and result
  logic [NUM_W-1:0]  num;
  logic [BS_W-1:0]   bs;
  logic [CMP_W-1:0]  bprod;
  logic [CMP_W-1:0]  tprod;
  logic [GATE_W-1:0] gprod;
  logic              gate_ok;
  logic              br_hit;
  logic              ta_hit;
  logic              res_asy;
  logic              res_br;
  logic              res_ta;
  logic [RATE_W-1:0] res_rate;
  logic              out_load;

  // Beat classification and pointer updates
  logic             accept;
  logic             is_asy;
  logic             is_store;
  logic [PTR_W-1:0] wp_next;
  logic [CNT_W-1:0] fill_next;

  logic              div_start;
  logic              div_done;
  logic [RATE_W-1:0] div_quot;

  assign beat.ready = (state == S_IDLE);
  assign accept     = beat.valid && beat.ready;
  assign is_asy     = beat.beat_present && (beat.rr_ms >= asy_limit);
  assign is_store   = beat.beat_present && !is_asy && (beat.rr_ms != '0) &&
                      (beat.rr_ms <= RR_W'(RR_VALID_MAX));
  assign wr_en      = accept && is_store;
  assign wp_next    = (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign fill_next  = (fill == CNT_W'(DEPTH)) ? fill : fill + 1'b1;

  assign rd_en      = (state == S_SCAN) && (iss != fill);
  assign acc_sum    = acc + ACC_W'(rr_q);

  // Alarm compares on registered products
  assign gate_ok    = GATE_W'(qacc) >= gprod;
  assign br_hit     = gate_ok && (CMP_W'(bs) < bprod);
  assign ta_hit     = gate_ok && !br_hit && (CMP_W'(bs) > tprod);
  assign div_start  = (state == S_CMP);

  // Output register takes a new result once it is free
  assign out_load   = (state == S_EMIT) && (!alarm.valid || alarm.ready);

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      asy_limit <= ASY_LIMIT_RST;
      window    <= WINDOW_RST;
      qgate     <= QGATE_RST;
      brady     <= BRADY_RST;
      tachy     <= TACHY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ASY_LIMIT: asy_limit <= cfg_data[RR_W-1:0];
        REG_WINDOW:    window    <= cfg_data[RR_W-1:0];
        REG_QGATE:     qgate     <= cfg_data[Q_W-1:0];
        REG_BRADY:     brady     <= cfg_data[BPM_W-1:0];
        REG_TACHY:     tachy     <= cfg_data[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rr_mem[wp] <= beat.rr_ms;
      q_mem[wp]  <= beat.quality;
    end
    if (rd_en) begin
      rr_q <= rr_mem[rd_idx];
      q_q  <= q_mem[rd_idx];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      asy_count <= '0;
      pend      <= 1'b0;
      alarm.valid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the beat is taken
      if (out_load) begin
        alarm.valid <= 1'b1;
      end else if (alarm.valid && alarm.ready) begin
        alarm.valid <= 1'b0;
      end
      pend <= rd_en;
      case (state)
        S_IDLE: begin
          res_asy  <= accept && is_asy;
          res_br   <= 1'b0;
          res_ta   <= 1'b0;
          res_rate <= '0;
          acc      <= '0;
          qacc     <= '0;
          n        <= '0;
          iss      <= '0;
          if (accept) begin
            if (is_asy) begin
              asy_count <= asy_count + 1'b1;
              state     <= S_EMIT;
            end else if (is_store) begin
              wp    <= wp_next;
              fill  <= fill_next;
              // Oldest entry: slot 0 until the ring fills, then the write slot
              rd_idx <= (fill_next == CNT_W'(DEPTH)) ? wp_next : '0;
              state <= S_SCAN;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          // Issue one read per cycle, fold in the entry read last cycle
          if (rd_en) begin
            iss    <= iss + 1'b1;
            rd_idx <= (rd_idx == PTR_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;
          end
          if (pend) begin
            acc  <= acc_sum;
            qacc <= qacc + QACC_W'(q_q);
            n    <= n + 1'b1;
            if (acc_sum >= ACC_W'(window)) begin
              state <= S_MUL;
            end
          end else if (iss == fill) begin
            state <= S_EMIT;
          end
        end
        S_MUL: begin
          num   <= NUM_W'(n) * NUM_W'(RATE_NUM_TENTHS);
          bs    <= BS_W'(n) * BS_W'(RATE_NUM_BPM);
          bprod <= CMP_W'(brady) * CMP_W'(acc);
          tprod <= CMP_W'(tachy) * CMP_W'(acc);
          gprod <= GATE_W'(qgate) * GATE_W'(n);
          state <= (n < CNT_W'(MIN_BEATS)) ? S_EMIT : S_CMP;
        end
        S_CMP: begin
          res_br <= br_hit;
          res_ta <= ta_hit;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_rate <= div_quot;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once it is free
          if (out_load) begin
            alarm.asystole       <= res_asy;
            alarm.bradycardia    <= res_br;
            alarm.tachycardia    <= res_ta;
            alarm.window_rate    <= res_rate;
            alarm.asystole_total <= asy_count;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  erw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (acc),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

### bench/erw_alarm_checker.sv
// erw_alarm_checker: watches the beat, alarm and register ports of the rhythm alarm,
// predicts every alarm beat and compares it field by field. Depends on erw_pkg,
// erw_beat_if and erw_alarm_if.
`timescale 1ns / 100ps

module erw_alarm_checker import erw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  erw_beat_if                   beat,
  erw_alarm_if                  alarm,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    backlog
);

  typedef struct packed {
    logic               asystole;
    logic               bradycardia;
    logic               tachycardia;
    logic [RATE_W-1:0]  window_rate;
    logic [TOTAL_W-1:0] asystole_total;
  } alarm_t;

  // Shadow copy of the alarm settings
  logic [RR_W-1:0]  asy_limit;
  logic [RR_W-1:0]  win_len;
  logic [Q_W-1:0]   q_gate;
  logic [BPM_W-1:0] brady_lim;
  logic [BPM_W-1:0] tachy_lim;

  // Shadow RR history
  logic [RR_W-1:0]    rr_ring [DEPTH];
  logic [Q_W-1:0]     q_ring  [DEPTH];
  logic [PTR_W-1:0]   ring_wr;
  int                 ring_fill;
  logic [TOTAL_W-1:0] asy_seen;

  alarm_t alarm_due [$];

  // Work out the alarm for one heartbeat record and advance the shadow history
  function automatic alarm_t score_beat(input logic present, input logic [RR_W-1:0] rr,
                                        input logic [Q_W-1:0] q);
    alarm_t                res;
    int                    start;
    int                    k;
    int unsigned           n;
    logic [PTR_W-1:0]      slot;
    logic [63:0]           span;
    logic [63:0]           q_sum;
    logic [63:0]           rate;
    logic [63:0]           scaled;
    res = '0;
    if (!present) begin
      res.asystole_total = asy_seen;
      return res;
    end
    // asystole wins over the range check, even for a zero RR
    if (rr >= asy_limit) begin
      asy_seen = asy_seen + 1'b1;
      res.asystole       = 1'b1;
      res.asystole_total = asy_seen;
      return res;
    end
    res.asystole_total = asy_seen;
    if (rr == 0 || rr > RR_VALID_MAX) return res;

    rr_ring[ring_wr] = rr;
    q_ring[ring_wr]  = q;
    ring_wr = ring_wr + 1'b1;
    if (ring_fill < DEPTH) ring_fill++;

    // Sum from the oldest entry until the window is covered
    start = (int'(ring_wr) + DEPTH - ring_fill) % DEPTH;
    span  = '0;
    q_sum = '0;
    n     = 0;
    k     = 0;
    while (k < ring_fill && (k == 0 || span < win_len)) begin
      slot  = PTR_W'((start + k) % DEPTH);
      span  = span + rr_ring[slot];
      q_sum = q_sum + q_ring[slot];
      n++;
      k++;
    end
    if (n < MIN_BEATS || span < win_len || span == 0) return res;

    rate = (64'(n) * 64'(RATE_NUM_TENTHS)) / span;
    res.window_rate = (rate > RATE_MAX) ? RATE_W'(RATE_MAX) : RATE_W'(rate);

    // Brady before tachy, both only with a good enough mean quality
    if (q_sum >= 64'(q_gate) * 64'(n)) begin
      scaled = 64'(n) * 64'(RATE_NUM_BPM);
      if (scaled < 64'(brady_lim) * span) res.bradycardia = 1'b1;
      else if (scaled > 64'(tachy_lim) * span) res.tachycardia = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    alarm_t got;
    alarm_t want;
    if (rst) begin
      asy_limit = ASY_LIMIT_RST;
      win_len   = WINDOW_RST;
      q_gate    = QGATE_RST;
      brady_lim = BRADY_RST;
      tachy_lim = TACHY_RST;
      ring_wr   = '0;
      ring_fill = 0;
      asy_seen  = '0;
      alarm_due.delete();
    end else begin
      // Track register writes, masked to each register's width
      if (cfg_we) begin
        case (cfg_index)
          REG_ASY_LIMIT: asy_limit = cfg_data[RR_W-1:0];
          REG_WINDOW:    win_len   = cfg_data[RR_W-1:0];
          REG_QGATE:     q_gate    = cfg_data[Q_W-1:0];
          REG_BRADY:     brady_lim = cfg_data[BPM_W-1:0];
          REG_TACHY:     tachy_lim = cfg_data[BPM_W-1:0];
          default: ;
        endcase
      end
      if (beat.valid && beat.ready)
        alarm_due.push_back(score_beat(beat.beat_present, beat.rr_ms, beat.quality));
      // Compare each alarm beat with the oldest prediction
      if (alarm.valid && alarm.ready) begin
        got = {alarm.asystole, alarm.bradycardia, alarm.tachycardia, alarm.window_rate,
               alarm.asystole_total};
        if (alarm_due.size() == 0) begin
          $error("alarm beat with no heartbeat outstanding");
          mismatches++;
        end else begin
          want = alarm_due.pop_front();
          check_field("asystole", want.asystole, got.asystole);
          check_field("bradycardia", want.bradycardia, got.bradycardia);
          check_field("tachycardia", want.tachycardia, got.tachycardia);
          check_field("window_rate", want.window_rate, got.window_rate);
          check_field("asystole_total", want.asystole_total, got.asystole_total);
        end
      end
    end
    backlog = alarm_due.size();
  end

endmodule

### bench/testbench.sv
// testbench: drives heartbeat records and alarm settings into ecg_rhythm_alarm_window
// and gives the verdict; prediction and comparison sit in erw_alarm_checker.
// Depends on erw_pkg, erw_beat_if, erw_alarm_if and the block itself.
`timescale 1ns / 100ps

module testbench;
  import erw_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  typedef enum int {NO_BEAT, ASYSTOLE_RR, BAD_RR, GOOD_RR} beat_kind_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    backlog;
  int                    gap_pct;
  int                    stall_pct;
  int                    stall_left;
  int                    limit_now;
  int                    cycle_count = 0;

  erw_beat_if  beat();
  erw_alarm_if alarm();

  ecg_rhythm_alarm_window u_dut (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .alarm     (alarm),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  erw_alarm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .alarm      (alarm),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Alarm receiver: stall in random bursts
  initial begin
    alarm.ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        alarm.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        alarm.ready <= 1'b0;
      end else begin
        alarm.ready <= 1'b1;
      end
    end
  end

  // Hold one heartbeat record until the block takes it
  task automatic send_beat(input logic present, input logic [RR_W-1:0] rr,
                           input logic [Q_W-1:0] q);
    beat.valid        <= 1'b1;
    beat.beat_present <= present;
    beat.rr_ms        <= rr;
    beat.quality      <= q;
    @(posedge clk);
    while (!beat.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Maybe idle for a burst, then send
  task automatic offer_beat(input logic present, input logic [RR_W-1:0] rr,
                            input logic [Q_W-1:0] q);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      beat.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    send_beat(present, rr, q);
  endtask

  // Stop sending and wait until every alarm beat is out
  task automatic settle();
    beat.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  // Upper data bits beyond the register width are random and must be dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value,
                           input int width);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'((64'($urandom) << width) | 64'(value));
    @(negedge clk);
  endtask

  task automatic program_alarms(input int asy_limit, input int win, input int gate,
                                input int brady, input int tachy);
    settle();
    write_reg(REG_ASY_LIMIT, asy_limit, RR_W);
    write_reg(REG_WINDOW, win, RR_W);
    write_reg(REG_QGATE, gate, Q_W);
    write_reg(REG_BRADY, brady, BPM_W);
    write_reg(REG_TACHY, tachy, BPM_W);
    cfg_we    <= 1'b0;
    limit_now = asy_limit;
  endtask

  // Random records; only stored and asystole beats count toward the total
  task automatic run_beats(input int count, input int rr_lo, input int rr_hi,
                           input int q_lo, input int gap, input int stall);
    int              taken;
    int              pick;
    beat_kind_t      kind;
    logic [RR_W-1:0] rr;
    logic [Q_W-1:0]  q;
    taken     = 0;
    gap_pct   = gap;
    stall_pct = stall;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) kind = NO_BEAT;
      else if (pick < 12) kind = ASYSTOLE_RR;
      else if (pick < 18) kind = BAD_RR;
      else kind = GOOD_RR;
      q = $urandom_range(q_lo, 1000);
      case (kind)
        NO_BEAT: offer_beat(1'b0, $urandom_range(0, 65535), q);
        ASYSTOLE_RR: begin
          offer_beat(1'b1, $urandom_range(limit_now, 65535), q);
          taken++;
        end
        BAD_RR: begin
          rr = $urandom_range(0, 1) ? RR_W'(0) : RR_W'($urandom_range(3001, 65535));
          offer_beat(1'b1, rr, q);
        end
        default: begin
          offer_beat(1'b1, $urandom_range(rr_lo, rr_hi), q);
          taken++;
        end
      endcase
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_ASY_LIMIT;
    cfg_data          = '0;
    beat.valid        = 1'b0;
    beat.beat_present = 1'b0;
    beat.rr_ms        = '0;
    beat.quality      = '0;
    gap_pct           = 0;
    stall_pct         = 20;
    limit_now         = ASY_LIMIT_RST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Writes past the last register must change nothing
    for (int idx = REG_TACHY + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), $urandom, CFG_DATA_W);
    cfg_we <= 1'b0;

    // Reset settings: no beat, asystole at and above the limit, RR out of range
    send_beat(1'b0, 16'hFFFF, 10'd1000);
    send_beat(1'b0, 16'd0, 10'd0);
    send_beat(1'b1, 16'hFFFF, 10'd0);
    send_beat(1'b1, 16'd4000, 10'd1000);
    send_beat(1'b1, 16'd3999, 10'd500);
    send_beat(1'b1, 16'd3001, 10'd1);
    send_beat(1'b1, 16'd0, 10'd1000);

    // Short window: first full window on the fifth beat, then RR extremes
    program_alarms(2500, 1000, 0, 250, 100);
    repeat (6) send_beat(1'b1, 16'd200, $urandom_range(0, 1000));
    send_beat(1'b1, 16'd1, 10'd0);
    send_beat(1'b1, 16'd3000, 10'd1000);
    send_beat(1'b1, 16'd2500, 10'd7);

    // Zero limit: a zero RR is asystole, a missing beat is not
    program_alarms(0, 1000, 0, 40, 150);
    send_beat(1'b1, 16'd0, 10'd1000);
    send_beat(1'b0, 16'd0, 10'd0);

    // Resting and active rates at the reset settings
    program_alarms(ASY_LIMIT_RST, WINDOW_RST, QGATE_RST, BRADY_RST, TACHY_RST);
    run_beats(250, 300, 2000, 0, 25, 25);
    // Tiny RR on the shortest window: the rate saturates
    program_alarms(3000, 1000, 0, 300, 0);
    run_beats(200, 1, 20, 0, 30, 10);
    // Widest limits: neither alarm can fire, gate at its top
    program_alarms(65535, 65535, 1000, 0, 300);
    run_beats(200, 1500, 3000, 990, 0, 40);
    // Strict gate met by every beat, brady nearly always
    program_alarms(2000, 5000, 1000, 300, 300);
    run_beats(200, 200, 1999, 1000, 40, 40);
    // Every present beat is asystole, zero RR included
    program_alarms(0, 1000, 0, 0, 0);
    run_beats(40, 0, 3000, 0, 20, 20);
    // Limit inside the valid RR range
    program_alarms(1200, 20000, 600, 60, 100);
    run_beats(250, 400, 1600, 300, 15, 50);
    // Closing stretch with no idling on either side
    program_alarms(4000, 10000, 450, 55, 110);
    run_beats(300, 300, 1500, 0, 0, 0);

    settle();
    repeat (DEPTH + 40) @(negedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
